/* rtl/lbcd_pkg.sv */
package lbcd_pkg;

   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 8;
   localparam int CFG_WIDTH       = 8;
   localparam int REPEAT_WIDTH    = 4;
   localparam int CODE_WIDTH      = 4;
   localparam int BIT_POS_WIDTH   = 2;
   localparam int PHASE_WIDTH     = 3;

   localparam logic [PHASE_WIDTH-1:0] PH_IDLE     = 3'd0;
   localparam logic [PHASE_WIDTH-1:0] PH_PULSE    = 3'd1;
   localparam logic [PHASE_WIDTH-1:0] PH_BITGAP   = 3'd2;
   localparam logic [PHASE_WIDTH-1:0] PH_NUMGAP   = 3'd3;
   localparam logic [PHASE_WIDTH-1:0] PH_GROUPGAP = 3'd4;

   localparam logic KIND_START = 1'b0;
   localparam logic KIND_TICK  = 1'b1;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_LONG_ON      = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_SHORT_ON     = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_BIT_GAP      = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_NUMBER_GAP   = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_GROUP_GAP    = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_REPEAT_TOTAL = 3'd5;

   localparam logic [CFG_WIDTH-1:0]    RST_LONG_ON      = 8'd10;
   localparam logic [CFG_WIDTH-1:0]    RST_SHORT_ON     = 8'd2;
   localparam logic [CFG_WIDTH-1:0]    RST_BIT_GAP      = 8'd2;
   localparam logic [CFG_WIDTH-1:0]    RST_NUMBER_GAP   = 8'd10;
   localparam logic [CFG_WIDTH-1:0]    RST_GROUP_GAP    = 8'd40;
   localparam logic [REPEAT_WIDTH-1:0] RST_REPEAT_TOTAL = 4'd3;

   typedef struct packed {
      logic                     found;
      logic [PHASE_WIDTH-1:0]   phase;
      logic [BIT_POS_WIDTH-1:0] bit_pos;
      logic [REPEAT_WIDTH-1:0]  rep;
   } step_type;

   // Which nonzero-length lit or dark stretch comes next within one showing
   function automatic step_type show_scan(
      input logic [CODE_WIDTH-1:0]    code,
      input logic [BIT_POS_WIDTH-1:0] b,
      input logic                     skip,
      input logic                     long_nz,
      input logic                     short_nz,
      input logic                     gap_nz,
      input logic                     num_nz);
      step_type s;
      logic     hit;
      s   = '{found: 1'b0, phase: PH_IDLE, bit_pos: '0, rep: '0};
      hit = 1'b0;
      if (!skip && (code[b] ? long_nz : short_nz)) begin
         s.found   = 1'b1;
         s.phase   = PH_PULSE;
         s.bit_pos = b;
      end else if (gap_nz && (b != '0)) begin
         s.found   = 1'b1;
         s.phase   = PH_BITGAP;
         s.bit_pos = b;
      end else if (!gap_nz) begin
         for (int p = 3; p >= 0; p--) begin
            if (!hit && ((p < int'(b)) || ((p == int'(b)) && !skip)) &&
                (code[p] ? long_nz : short_nz)) begin
               hit       = 1'b1;
               s.found   = 1'b1;
               s.phase   = PH_PULSE;
               s.bit_pos = BIT_POS_WIDTH'(p);
            end
         end
      end
      if (!s.found && num_nz) begin
         s.found   = 1'b1;
         s.phase   = PH_NUMGAP;
         s.bit_pos = '0;
      end
      return s;
   endfunction

   function automatic step_type group_entry(
      input logic [REPEAT_WIDTH-1:0] rep,
      input logic                    group_nz);
      step_type s;
      s = '{found: 1'b1, phase: PH_IDLE, bit_pos: '0, rep: '0};
      if (group_nz) begin
         s.phase = PH_GROUPGAP;
         s.rep   = rep;
      end
      return s;
   endfunction

   // End of one showing: next showing, the closing group gap, or idle when that gap is zero
   function automatic step_type repeat_exit(
      input logic [REPEAT_WIDTH-1:0] rep,
      input logic [REPEAT_WIDTH-1:0] total,
      input logic [CODE_WIDTH-1:0]   code,
      input logic                    long_nz,
      input logic                    short_nz,
      input logic                    gap_nz,
      input logic                    num_nz,
      input logic                    group_nz);
      step_type s;
      if (({1'b0, rep} + 5'd1) >= {1'b0, total}) begin
         s = group_entry(rep, group_nz);
      end else begin
         s = show_scan(code, 2'd3, 1'b0, long_nz, short_nz, gap_nz, num_nz);
         if (s.found) begin
            s.rep = rep + 4'd1;
         end else begin
            // no showing holds any nonzero stretch: all repeats collapse
            s = group_entry(total - 4'd1, group_nz);
         end
      end
      return s;
   endfunction

endpackage

/* rtl/led_blink_code_display.sv */
// LED blink code display. A start transaction (kind 0) latches a 4-bit code, drives it onto
// shown_code at once and blinks it on one LED, most significant bit first: a long lit pulse
// for a one, a short one for a zero, dark bit gaps between pulses and a dark number gap after
// each showing. The code is shown repeat_total times (zero acts as one), then a dark group gap
// runs before the block goes idle. Tick transactions (kind 1) advance all timing by one tick;
// phases of zero length are passed over within the same transaction. A start while busy and a
// tick while idle change nothing. Every transaction gives exactly one response reporting the
// LED level, busy and the latched code after it. One transaction is taken per clock: the whole
// update is one registered pass from the state registers to the response register, and the
// only back-pressure comes from a full response register that is stalled. The user must write
// configuration registers through the csr port while no sequence is running; the block does
// not enforce it. Indexes 6, 7 are ignored. Phase lengths over TICK_COUNT_WIDTH bits saturate.
module led_blink_code_display
   import lbcd_pkg::*;
#(
   parameter int TICK_COUNT_WIDTH = 8
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic                       req_kind,
   input  logic [CODE_WIDTH-1:0]      req_code_value,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic                       rsp_led_lit,
   output logic                       rsp_busy_res,
   output logic [CODE_WIDTH-1:0]      rsp_shown_code,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wdata
);

   localparam int TW = TICK_COUNT_WIDTH;
   localparam int CW = (TW > CFG_WIDTH) ? TW : CFG_WIDTH;
   localparam logic [CW-1:0] TICK_MAX = CW'({TW{1'b1}});

   function automatic logic [TW-1:0] count_load(input logic [CFG_WIDTH-1:0] v);
      logic [CW-1:0] ext;
      ext = CW'(v);
      return (ext > TICK_MAX) ? TW'(TICK_MAX) : TW'(ext);
   endfunction

   logic [CFG_WIDTH-1:0]    long_on_ff, short_on_ff, bit_gap_ff, number_gap_ff, group_gap_ff;
   logic [REPEAT_WIDTH-1:0] repeat_total_ff;

   logic [PHASE_WIDTH-1:0]   phase_ff, phase_in;
   logic [BIT_POS_WIDTH-1:0] bit_pos_ff, bit_pos_in;
   logic [REPEAT_WIDTH-1:0]  rep_ff, rep_in;
   logic [TW-1:0]            ticks_ff, ticks_in;
   logic [CODE_WIDTH-1:0]    code_ff, code_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  led_ff, busy_ff;
   logic [CODE_WIDTH-1:0] shown_ff;

   logic     accept;
   logic     long_nz, short_nz, gap_nz, num_nz, group_nz;
   logic     reload;
   step_type s;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;
   assign csr_ready = 1'b1;

   assign long_nz  = long_on_ff != '0;
   assign short_nz = short_on_ff != '0;
   assign gap_nz   = bit_gap_ff != '0;
   assign num_nz   = number_gap_ff != '0;
   assign group_nz = group_gap_ff != '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         long_on_ff      <= RST_LONG_ON;
         short_on_ff     <= RST_SHORT_ON;
         bit_gap_ff      <= RST_BIT_GAP;
         number_gap_ff   <= RST_NUMBER_GAP;
         group_gap_ff    <= RST_GROUP_GAP;
         repeat_total_ff <= RST_REPEAT_TOTAL;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_LONG_ON:      long_on_ff      <= csr_wdata;
            REG_SHORT_ON:     short_on_ff     <= csr_wdata;
            REG_BIT_GAP:      bit_gap_ff      <= csr_wdata;
            REG_NUMBER_GAP:   number_gap_ff   <= csr_wdata;
            REG_GROUP_GAP:    group_gap_ff    <= csr_wdata;
            REG_REPEAT_TOTAL: repeat_total_ff <= csr_wdata[REPEAT_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      phase_in   = phase_ff;
      bit_pos_in = bit_pos_ff;
      rep_in     = rep_ff;
      ticks_in   = ticks_ff;
      code_in    = code_ff;
      reload     = 1'b0;
      s          = '{found: 1'b0, phase: PH_IDLE, bit_pos: '0, rep: '0};
      if (accept) begin
         if (req_kind == KIND_START) begin
            if (phase_ff == PH_IDLE) begin
               code_in = req_code_value;
               reload  = 1'b1;
               s = show_scan(req_code_value, 2'd3, 1'b0,
                             long_nz, short_nz, gap_nz, num_nz);
               if (!s.found) begin
                  s = repeat_exit('0, repeat_total_ff, req_code_value,
                                  long_nz, short_nz, gap_nz, num_nz, group_nz);
               end
            end
         end else if (phase_ff != PH_IDLE) begin
            if (ticks_ff != TW'(1)) begin
               ticks_in = ticks_ff - TW'(1);
            end else begin
               reload = 1'b1;
               unique case (phase_ff)
                  PH_PULSE: begin
                     s = show_scan(code_ff, bit_pos_ff, 1'b1,
                                   long_nz, short_nz, gap_nz, num_nz);
                     s.rep = rep_ff;
                  end
                  PH_BITGAP: begin
                     s = show_scan(code_ff, bit_pos_ff - 2'd1, 1'b0,
                                   long_nz, short_nz, gap_nz, num_nz);
                     s.rep = rep_ff;
                  end
                  PH_NUMGAP: s = '{found: 1'b0, phase: PH_IDLE, bit_pos: '0, rep: rep_ff};
                  default:   s = '{found: 1'b1, phase: PH_IDLE, bit_pos: '0, rep: '0};
               endcase
               if (!s.found) begin
                  s = repeat_exit(rep_ff, repeat_total_ff, code_ff,
                                  long_nz, short_nz, gap_nz, num_nz, group_nz);
               end
            end
         end
      end
      if (reload) begin
         phase_in   = s.phase;
         bit_pos_in = s.bit_pos;
         rep_in     = s.rep;
         unique case (s.phase)
            PH_PULSE:    ticks_in = count_load(code_in[s.bit_pos] ? long_on_ff : short_on_ff);
            PH_BITGAP:   ticks_in = count_load(bit_gap_ff);
            PH_NUMGAP:   ticks_in = count_load(number_gap_ff);
            PH_GROUPGAP: ticks_in = count_load(group_gap_ff);
            default:     ticks_in = '0;
         endcase
      end
   end

   assign rsp_valid_in = accept | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         bit_pos_ff   <= '0;
         rep_ff       <= '0;
         ticks_ff     <= '0;
         code_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         bit_pos_ff   <= bit_pos_in;
         rep_ff       <= rep_in;
         ticks_ff     <= ticks_in;
         code_ff      <= code_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         led_ff   <= phase_in == PH_PULSE;
         busy_ff  <= phase_in != PH_IDLE;
         shown_ff <= code_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_led_lit    = led_ff;
   assign rsp_busy_res   = busy_ff;
   assign rsp_shown_code = shown_ff;

endmodule
